[rtl/core/tdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  // width of the number under test, range 8 to 32 on this port width
  localparam int NumWidth = 32;
  localparam int CntWidth = $clog2(NumWidth + 1);

  // stream payload widths
  localparam int InDataWidth  = 32;
  localparam int OutDataWidth = 8;

  // wheel constants
  localparam logic [NumWidth-1:0] Two   = NumWidth'(2);
  localparam logic [NumWidth-1:0] Three = NumWidth'(3);
  localparam logic [NumWidth-1:0] Five  = NumWidth'(5);
  localparam logic [NumWidth-1:0] Six   = NumWidth'(6);

  typedef struct packed {
    logic                start;
    logic [NumWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic                rem_zero;
    logic [NumWidth-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/trial_division_prime_test.sv]
`timescale 1ns / 1ps
`default_nettype none

// Trial-division primality test on the 6k +/- 1 wheel. Each transfer on the
// slave stream carries one unsigned candidate; exactly one transfer comes
// back on the master stream with is_prime set when the candidate is prime.
// Zero and one give 0, two and three give 1, even numbers give 0. Every
// other candidate is first divided by 3 and then by the pairs d and d+2 for
// d = 5, 11, 17, ... until a remainder is zero or d*d exceeds the candidate.
// All divisions go through one restoring divider that makes one quotient bit
// per cycle. One candidate is tested at a time: s_axis_tready is high only
// while the sequencer is idle. The result sits in an output register, so a
// new candidate is taken while the previous answer waits.
module trial_division_prime_test import tdp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,   // [31:0] candidate
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OutDataWidth-1:0]      m_axis_tdata    // [0] is_prime, [7:1] zero
);

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [NumWidth-1:0] dividend;
  logic                res_valid;
  logic                res_bit;
  logic                res_ready;
  logic                out_valid_q;
  logic                out_bit_q;

  // output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  tdp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_num_i    (NumWidth'(s_axis_tdata)),
    .in_ready_o  (s_axis_tready),
    .res_valid_o (res_valid),
    .res_bit_o   (res_bit),
    .res_ready_i (res_ready),
    .div_req_o   (div_req),
    .dividend_o  (dividend),
    .div_rsp_i   (div_rsp)
  );

  tdp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (dividend),
    .rsp_o      (div_rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
        out_bit_q   <= res_bit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataWidth-1){1'b0}}, out_bit_q};

endmodule

`default_nettype wire

[rtl/core/tdp_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module tdp_div import tdp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire div_req_t            req_i,
  input  wire logic [NumWidth-1:0] dividend_i,
  output div_rsp_t                 rsp_o
);

  logic [NumWidth-1:0] quo_q, quo_d;
  logic [NumWidth-1:0] rem_q, rem_d;
  logic [NumWidth-1:0] div_q;
  logic [CntWidth-1:0] cnt_q;
  logic                active_q;
  logic                done_q;
  logic [NumWidth:0]   shifted;
  logic [NumWidth:0]   diff;
  logic                ge;

  always_comb begin
    shifted = {rem_q, quo_q[NumWidth-1]};
    diff    = shifted - {1'b0, div_q};
    ge      = shifted >= {1'b0, div_q};
    rem_d   = ge ? diff[NumWidth-1:0] : shifted[NumWidth-1:0];
    quo_d   = {quo_q[NumWidth-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= CntWidth'(NumWidth);
      end else if (active_q) begin
        cnt_q <= cnt_q - CntWidth'(1);
        if (cnt_q == CntWidth'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (active_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

[rtl/core/tdp_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

// wheel sequencer: screens small cases, then walks d = 5, 11, 17, ...
module tdp_seq import tdp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [NumWidth-1:0] in_num_i,
  output logic                     in_ready_o,
  output logic                     res_valid_o,
  output logic                     res_bit_o,
  input  wire logic                res_ready_i,
  output div_req_t                 div_req_o,
  output logic [NumWidth-1:0]      dividend_o,
  input  wire div_rsp_t            div_rsp_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV3,
    S_DIVA,
    S_DIVB,
    S_RES
  } state_e;

  state_e              state_q;
  logic [NumWidth-1:0] num_q;
  logic [NumWidth-1:0] trial_q;
  logic                res_q;
  div_req_t            req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      num_q   <= '0;
      trial_q <= '0;
      res_q   <= 1'b0;
      req_q   <= '0;
    end else begin
      req_q.start <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            num_q   <= in_num_i;
            trial_q <= '0;
            if (in_num_i < Two) begin
              res_q   <= 1'b0;
              state_q <= S_RES;
            end else if (in_num_i <= Three) begin
              res_q   <= 1'b1;
              state_q <= S_RES;
            end else if (!in_num_i[0]) begin
              res_q   <= 1'b0;
              state_q <= S_RES;
            end else begin
              req_q.start   <= 1'b1;
              req_q.divisor <= Three;
              state_q       <= S_DIV3;
            end
          end
        end
        S_DIV3: begin
          if (div_rsp_i.done) begin
            if (div_rsp_i.rem_zero) begin
              res_q   <= 1'b0;
              state_q <= S_RES;
            end else begin
              trial_q       <= Five;
              req_q.start   <= 1'b1;
              req_q.divisor <= Five;
              state_q       <= S_DIVA;
            end
          end
        end
        S_DIVA: begin
          // quotient below d means d*d exceeds the number
          if (div_rsp_i.done) begin
            if (trial_q > div_rsp_i.quotient) begin
              res_q   <= 1'b1;
              state_q <= S_RES;
            end else if (div_rsp_i.rem_zero) begin
              res_q   <= 1'b0;
              state_q <= S_RES;
            end else begin
              req_q.start   <= 1'b1;
              req_q.divisor <= trial_q + Two;
              state_q       <= S_DIVB;
            end
          end
        end
        S_DIVB: begin
          if (div_rsp_i.done) begin
            if (div_rsp_i.rem_zero) begin
              res_q   <= 1'b0;
              state_q <= S_RES;
            end else begin
              trial_q       <= trial_q + Six;
              req_q.start   <= 1'b1;
              req_q.divisor <= trial_q + Six;
              state_q       <= S_DIVA;
            end
          end
        end
        S_RES: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RES);
  assign res_bit_o   = res_q;
  assign div_req_o   = req_q;
  assign dividend_o  = num_q;

endmodule

`default_nettype wire

[rtl/core/tdp_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdp_chk import tdp_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tvalid,
  input wire logic                    s_axis_tready,
  input wire logic [InDataWidth-1:0]  s_axis_tdata,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one candidate at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after a transfer");

  // a fresh result only comes out of a busy sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a test in progress");

  // padding bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataWidth-1:1] == '0)
    else $error("nonzero padding in result");

endmodule

bind trial_division_prime_test tdp_chk u_chk (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// primality tester bench: a table of directed candidates, then random
// candidates in three idling phases, every answer checked in order against
// the table's verdict where one is given, else a 6k +/- 1 trial-division predictor kept in the bench
module testbench;
  import tdp_pkg::*;

  // generous cycle budget, far above the slowest legal run of this stimulus
  localparam int unsigned CycleLimit   = 4_000_000;
  localparam int          RandomPerPhase = 26;
  localparam int          TailCycles   = 200;

  // one row of the directed table; verdict only matters when typed is set
  typedef struct packed {
    logic [InDataWidth-1:0] value;
    bit                     typed;
    bit                     verdict;
  } probe_row_t;

  // one answer still owed by the block
  typedef struct packed {
    logic [InDataWidth-1:0] candidate;
    bit                     verdict;
  } owed_answer_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;   // [31:0] candidate
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;        // [0] is_prime, [7:1] zero

  owed_answer_t owed_answers[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int unsigned  cycle_count = 0;
  int           mismatch_count = 0;
  int           answers_checked = 0;
  int           primes_seen = 0;
  int           candidates_sent = 0;

  // directed candidates: edges of the range, the small primes, squares and
  // products caught by the d or the d+2 divisor of a pair or by both, and a
  // couple of larger primes that run the wheel for a while
  probe_row_t probe_rows [24] = '{
    '{32'd0,          1'b1, 1'b0},  // zero, not prime
    '{32'd1,          1'b1, 1'b0},  // one, not prime
    '{32'd2,          1'b1, 1'b1},  // two, prime
    '{32'd3,          1'b1, 1'b1},  // three, prime
    '{32'd4,          1'b1, 1'b0},  // even
    '{32'd5,          1'b0, 1'b0},
    '{32'd9,          1'b1, 1'b0},  // multiple of three
    '{32'd7,          1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0},  // caught by d
    '{32'd35,         1'b0, 1'b0},  // caught by d and d+2
    '{32'd49,         1'b0, 1'b0},  // caught by d+2 only
    '{32'd121,        1'b0, 1'b0},  // second pair, d
    '{32'd169,        1'b0, 1'b0},  // second pair, d+2
    '{32'd255,        1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b1, 1'b0},  // all ones, divisible by three
    '{32'hFFFF_FFFE,  1'b1, 1'b0},  // even
    '{32'h8000_0000,  1'b1, 1'b0},  // top bit alone, even
    '{32'hAAAA_AAAA,  1'b1, 1'b0},  // even
    '{32'h5555_5555,  1'b0, 1'b0},  // multiple of five
    '{32'd65521,      1'b0, 1'b0},
    '{32'd65537,      1'b0, 1'b0},
    '{32'd1000003,    1'b0, 1'b0},
    '{32'd16752649,   1'b0, 1'b0},  // square of a prime, found at the bound
    '{32'd16777213,   1'b0, 1'b0}   // prime just under 2^24
  };

  trial_division_prime_test DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // primality by the 6k +/- 1 wheel, bound tested as d <= n / d
  function automatic bit prime_by_wheel(input logic [InDataWidth-1:0] candidate);
    longint unsigned num;
    longint unsigned d;
    num = longint'(candidate) & ((64'd1 << NumWidth) - 64'd1);
    if (num < 2) return 1'b0;
    if (num <= 3) return 1'b1;
    if (num % 2 == 0 || num % 3 == 0) return 1'b0;
    for (d = 5; d <= num / d; d += 6) begin
      if (num % d == 0 || num % (d + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly short numbers, where primes are common and the wheel runs to the
  // bound; the rest are full 32-bit numbers forced onto a small factor so
  // that the block answers them quickly
  function automatic logic [InDataWidth-1:0] next_candidate();
    logic [InDataWidth-1:0] raw;
    int unsigned            factor;
    int unsigned            bits;
    raw = $urandom;
    if ($urandom_range(0, 9) < 6) begin
      bits = $urandom_range(1, 18);
      return raw & ((32'd1 << bits) - 32'd1);
    end
    factor = $urandom_range(2, 97);
    return raw - (raw % factor);
  endfunction

  // offers one candidate; starts and returns at a falling edge
  task automatic offer_candidate(input logic [InDataWidth-1:0] value, input bit typed,
                                 input bit verdict);
    owed_answer_t owed;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    // transfer taken on this edge
    owed.candidate = value;
    owed.verdict   = typed ? verdict : prime_by_wheel(value);
    owed_answers.push_back(owed);
    candidates_sent++;
    @(negedge clk_i);
  endtask

  // sender holds off until every owed answer is back; starts and ends at a
  // falling edge
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stalls at random, at the rate of the current phase
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // answer checker: each transfer against the oldest owed answer
  always @(posedge clk_i) begin
    owed_answer_t owed;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected answer, actual tdata %h", $realtime, m_axis_tdata);
        mismatch_count++;
      end else begin
        owed = owed_answers.pop_front();
        answers_checked++;
        if (owed.verdict) primes_seen++;
        if (m_axis_tdata !== OutDataWidth'(owed.verdict)) begin
          $display("%0t: candidate %0d, expected tdata %h, actual tdata %h", $realtime,
                   owed.candidate, OutDataWidth'(owed.verdict), m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d answers still owed", $realtime, owed_answers.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, sender seldom idle, receiver mostly stalled
    send_idle_pct  = 9;
    recv_stall_pct = 79;
    foreach (probe_rows[i]) begin
      offer_candidate(probe_rows[i].value, probe_rows[i].typed, probe_rows[i].verdict);
    end
    hold_until_drained();

    // random phases: slow receiver, then slow sender, then no idling at all
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 79 : 0;
      recv_stall_pct = (phase == 0) ? 79 : (phase == 1) ? 9 : 0;
      repeat (RandomPerPhase) offer_candidate(next_candidate(), 1'b0, 1'b0);
      hold_until_drained();
    end

    // catch any stray transfer after the last answer
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d candidates (%0d directed), %0d answers checked, %0d primes",
             candidates_sent, $size(probe_rows), answers_checked, primes_seen);
    $display("idling phases: slow receiver, slow sender, none; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && owed_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
